### hw/rtl/rc4_pkg.sv
package rc4_pkg;

  // Box geometry
  localparam int BoxSize = 256;
  localparam int BoxAw   = 8;

  // Key store geometry
  localparam int KeyDepth = 256;
  localparam int KeyAw    = (KeyDepth > 1) ? $clog2(KeyDepth) : 1;

  // Key length register width
  localparam int KlenW = 9;

  // Request modes
  localparam logic [1:0] MODE_KEY   = 2'd0;
  localparam logic [1:0] MODE_SCHED = 2'd1;
  localparam logic [1:0] MODE_CRYPT = 2'd2;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_FILL,
    ST_IDLE,
    ST_CR_J,
    ST_CR_SWAP,
    ST_CR_OUT,
    ST_KS_RD,
    ST_KS_J,
    ST_KS_WN,
    ST_KS_WJ
  } rc4_state_e;

  // Box memory access
  typedef struct packed {
    logic             we;
    logic [BoxAw-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [BoxAw-1:0] raddr;
  } rc4_box_req_t;

  // Key memory access
  typedef struct packed {
    logic             we;
    logic [KeyAw-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [KeyAw-1:0] raddr;
  } rc4_key_req_t;

  // Result handed to the output register
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } rc4_res_t;

endpackage

### hw/rtl/rc4_box_ram.sv
module rc4_box_ram
  import rc4_pkg::*;
(
  input  logic         clk_i,
  input  rc4_box_req_t req_i,
  output logic [7:0]   rdata_o
);

  logic [7:0] mem_q [BoxSize];
  logic [7:0] rdata_q;

  // One write, one registered read; read sees old data on collision
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/rc4_key_ram.sv
module rc4_key_ram
  import rc4_pkg::*;
(
  input  logic         clk_i,
  input  rc4_key_req_t req_i,
  output logic [7:0]   rdata_o
);

  logic [7:0] mem_q [KeyDepth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/rc4_ctrl.sv
module rc4_ctrl
  import rc4_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // request side
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  logic [1:0]       mode_i,
  input  logic [7:0]       key_index_i,
  input  logic [7:0]       value_i,
  // key length register
  input  logic             cfg_we_i,
  input  logic [KlenW-1:0] cfg_wdata_i,
  // result side
  input  logic             out_free_i,
  output rc4_res_t         res_o,
  // memories
  output rc4_box_req_t     box_req_o,
  input  logic [7:0]       box_rdata_i,
  output rc4_key_req_t     key_req_o,
  input  logic [7:0]       key_rdata_i
);

  rc4_state_e state_q, state_d;

  logic [BoxAw-1:0] n_q;
  logic [7:0]       i_q, j_q;
  logic [7:0]       si_q, sj_q, t_q, val_q;
  logic [KeyAw-1:0] ki_q, ki_next;
  logic             ks_q;
  logic [KlenW-1:0] key_length_q, len_eff;
  logic             accept;
  logic             last_n;
  logic [7:0]       ks_byte;

  assign accept = req_valid_i && (state_q == ST_IDLE);
  assign last_n = (n_q == BoxAw'(BoxSize - 1));

  // Zero or oversized length means the whole store
  always_comb begin
    len_eff = key_length_q;
    if (key_length_q == '0 || key_length_q > KlenW'(KeyDepth)) begin
      len_eff = KlenW'(KeyDepth);
    end
  end

  // Cyclic key position
  always_comb begin
    if ((KlenW'(ki_q) + KlenW'(1)) == len_eff) begin
      ki_next = '0;
    end else begin
      ki_next = ki_q + KeyAw'(1);
    end
  end

  // Keystream byte, forwarded around the swap written this step
  always_comb begin
    if (t_q == j_q) begin
      ks_byte = si_q;
    end else if (t_q == i_q) begin
      ks_byte = sj_q;
    end else begin
      ks_byte = box_rdata_i;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_FILL: begin
        if (last_n) begin
          state_d = ks_q ? ST_KS_RD : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (mode_i)
            MODE_SCHED: state_d = ST_FILL;
            MODE_CRYPT: state_d = ST_CR_J;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_CR_J:    state_d = ST_CR_SWAP;
      ST_CR_SWAP: state_d = ST_CR_OUT;
      ST_CR_OUT: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      ST_KS_RD: state_d = ST_KS_J;
      ST_KS_J:  state_d = ST_KS_WN;
      ST_KS_WN: state_d = ST_KS_WJ;
      ST_KS_WJ: state_d = last_n ? ST_IDLE : ST_KS_RD;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs: handshake, memory accesses, result
  always_comb begin
    req_ready_o     = 1'b0;
    box_req_o       = '0;
    key_req_o       = '0;
    res_o           = '0;
    case (state_q)
      ST_FILL: begin
        box_req_o.we    = 1'b1;
        box_req_o.waddr = n_q;
        box_req_o.wdata = 8'(n_q);
      end
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (accept && mode_i == MODE_CRYPT) begin
          box_req_o.re    = 1'b1;
          box_req_o.raddr = i_q + 8'd1;
        end
        if (accept && mode_i == MODE_KEY && (KlenW'(key_index_i) < KlenW'(KeyDepth))) begin
          key_req_o.we    = 1'b1;
          key_req_o.waddr = key_index_i[KeyAw-1:0];
          key_req_o.wdata = value_i;
        end
      end
      ST_CR_J: begin
        box_req_o.re    = 1'b1;
        box_req_o.raddr = j_q + box_rdata_i;
      end
      ST_CR_SWAP: begin
        box_req_o.we    = 1'b1;
        box_req_o.waddr = i_q;
        box_req_o.wdata = box_rdata_i;
        box_req_o.re    = 1'b1;
        box_req_o.raddr = si_q + box_rdata_i;
      end
      ST_CR_OUT: begin
        box_req_o.we    = 1'b1;
        box_req_o.waddr = j_q;
        box_req_o.wdata = si_q;
        res_o.valid     = out_free_i;
        res_o.data      = val_q ^ ks_byte;
      end
      ST_KS_RD: begin
        box_req_o.re    = 1'b1;
        box_req_o.raddr = n_q;
        key_req_o.re    = 1'b1;
        key_req_o.raddr = ki_q;
      end
      ST_KS_J: begin
        box_req_o.re    = 1'b1;
        box_req_o.raddr = j_q + box_rdata_i + key_rdata_i;
      end
      ST_KS_WN: begin
        box_req_o.we    = 1'b1;
        box_req_o.waddr = n_q;
        box_req_o.wdata = box_rdata_i;
      end
      ST_KS_WJ: begin
        box_req_o.we    = 1'b1;
        box_req_o.waddr = j_q;
        box_req_o.wdata = si_q;
      end
      default: begin
        req_ready_o = 1'b0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_FILL;
      n_q          <= '0;
      i_q          <= '0;
      j_q          <= '0;
      ks_q         <= 1'b0;
      key_length_q <= KlenW'(256);
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        key_length_q <= cfg_wdata_i;
      end
      case (state_q)
        ST_FILL: begin
          n_q <= n_q + BoxAw'(1);
          j_q <= '0;
        end
        ST_IDLE: begin
          if (accept && mode_i == MODE_CRYPT) begin
            i_q <= i_q + 8'd1;
          end
          if (accept && mode_i == MODE_SCHED) begin
            ks_q <= 1'b1;
          end
        end
        ST_CR_J: begin
          j_q <= j_q + box_rdata_i;
        end
        ST_KS_J: begin
          j_q <= j_q + box_rdata_i + key_rdata_i;
        end
        ST_KS_WJ: begin
          n_q <= n_q + BoxAw'(1);
          if (last_n) begin
            ks_q <= 1'b0;
            i_q  <= '0;
            j_q  <= '0;
          end
        end
        default: begin
          ks_q <= ks_q;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_FILL: begin
        ki_q <= '0;
      end
      ST_IDLE: begin
        if (accept) begin
          val_q <= value_i;
        end
      end
      ST_CR_J: begin
        si_q <= box_rdata_i;
      end
      ST_CR_SWAP: begin
        sj_q <= box_rdata_i;
        t_q  <= si_q + box_rdata_i;
      end
      ST_KS_J: begin
        si_q <= box_rdata_i;
        ki_q <= ki_next;
      end
      default: begin
        val_q <= val_q;
      end
    endcase
  end

endmodule

### hw/rtl/rc4_stream_cipher.sv
// Channel   Dir  Signals                      Contents
// request   in   s_axis_tvalid/tready         tuser: mode; tdata: key_index, value
// result    out  m_axis_tvalid/tready         tdata: out_byte
// config    in   cfg_we_i, cfg_wdata_i        key_length (9 bits)
//
// A crypt request steps through accept, two dependent box reads and the swap
// write-back; the single-port-read box memory sets that order. A key schedule
// runs accept, the identity fill, then one swap step per box entry.
// After reset the box is filled with identity; tready is low. A key load or
// an ignored mode completes at accept. A crypt result waits in the output
// register; the next crypt holds in its last step while it is full and unread.
module rc4_stream_cipher
  import rc4_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // request stream
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [15:0]      s_axis_tdata_i,   // [7:0] key_index, [15:8] value
  input  logic [1:0]       s_axis_tuser_i,   // [1:0] mode
  // result stream
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,   // [7:0] out_byte
  // key length register
  input  logic             cfg_we_i,
  input  logic [KlenW-1:0] cfg_wdata_i
);

  rc4_box_req_t box_req;
  rc4_key_req_t key_req;
  rc4_res_t     res;
  logic [7:0]   box_rdata, key_rdata;
  logic         out_free;
  logic         out_valid_q;
  logic [7:0]   out_data_q;

  assign out_free = !out_valid_q || m_axis_tready_i;

  rc4_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .mode_i      (s_axis_tuser_i),
    .key_index_i (s_axis_tdata_i[7:0]),
    .value_i     (s_axis_tdata_i[15:8]),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_free_i  (out_free),
    .res_o       (res),
    .box_req_o   (box_req),
    .box_rdata_i (box_rdata),
    .key_req_o   (key_req),
    .key_rdata_i (key_rdata)
  );

  rc4_box_ram u_box_ram (
    .clk_i   (clk_i),
    .req_i   (box_req),
    .rdata_o (box_rdata)
  );

  rc4_key_ram u_key_ram (
    .clk_i   (clk_i),
    .req_i   (key_req),
    .rdata_o (key_rdata)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_data_q <= res.data;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
